// ----- rtl/color_threshold_centroid_defines.svh -----
// Assertion macros used by the color threshold centroid back end
`ifndef COLOR_THRESHOLD_CENTROID_DEFINES_SVH
`define COLOR_THRESHOLD_CENTROID_DEFINES_SVH

// Checked on clk_i, off while rst_ni is low.
`define CTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on clk_i, also during reset.
`define CTC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/ctc_pkg.sv -----
// Shared constants and types of the color threshold centroid block
`timescale 1ns / 1ps

package ctc_pkg;

  localparam int PixW     = 8;
  localparam int MinW     = 16;
  localparam int PosW     = 11;
  localparam int SumW     = 33;
  localparam int CntW     = 23;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int PosMax   = 2047;

  localparam int DefMaxCols    = 2048;
  localparam int DefMaxRows    = 2048;
  localparam int DefQueueDepth = 4;

  localparam logic [PixW-1:0] HueLowRst  = 8'd111;
  localparam logic [PixW-1:0] HueHighRst = 8'd155;
  localparam logic [PixW-1:0] SatLowRst  = 8'd178;
  localparam logic [PixW-1:0] SatHighRst = 8'd255;
  localparam logic [PixW-1:0] ValLowRst  = 8'd0;
  localparam logic [PixW-1:0] ValHighRst = 8'd255;
  localparam logic [MinW-1:0] MinPixRst  = 16'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HUE_LOW   = 3'd0,
    REG_HUE_HIGH  = 3'd1,
    REG_SAT_LOW   = 3'd2,
    REG_SAT_HIGH  = 3'd3,
    REG_VAL_LOW   = 3'd4,
    REG_VAL_HIGH  = 3'd5,
    REG_MIN_PIXEL = 3'd6
  } cfg_reg_e;

  // One classified pixel handed from front to back; sums valid on frame end.
  typedef struct packed {
    logic            mask;
    logic            frame_end;
    logic            found;
    logic [SumW-1:0] col_sum;
    logic [SumW-1:0] row_sum;
    logic [CntW-1:0] count;
  } entry_t;

endpackage

// ----- rtl/ctc_front.sv -----
// Front end: config registers, HSV range test, position tracking and sums
`timescale 1ns / 1ps

module ctc_front #(
  parameter int MaxCols = ctc_pkg::DefMaxCols,
  parameter int MaxRows = ctc_pkg::DefMaxRows
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ctc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ctc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ctc_pkg::PixW-1:0]     hue_i,
  input  logic [ctc_pkg::PixW-1:0]     sat_i,
  input  logic [ctc_pkg::PixW-1:0]     val_i,
  input  logic                         row_end_i,
  input  logic                         frame_end_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output ctc_pkg::entry_t              push_data_o
);

  localparam int PosW = ctc_pkg::PosW;
  localparam int SumW = ctc_pkg::SumW;
  localparam int CntW = ctc_pkg::CntW;
  localparam int ColLim = (MaxCols - 1 > ctc_pkg::PosMax) ? ctc_pkg::PosMax : MaxCols - 1;
  localparam int RowLim = (MaxRows - 1 > ctc_pkg::PosMax) ? ctc_pkg::PosMax : MaxRows - 1;
  localparam logic [PosW-1:0] COL_LIM = PosW'(ColLim);
  localparam logic [PosW-1:0] ROW_LIM = PosW'(RowLim);

  logic [ctc_pkg::PixW-1:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q;
  logic [ctc_pkg::PixW-1:0] val_low_q, val_high_q;
  logic [ctc_pkg::MinW-1:0] min_pix_q;

  logic [PosW-1:0] col_pos_q, row_pos_q;
  logic [SumW-1:0] col_sum_q, row_sum_q, col_sum_d, row_sum_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW:0]   col_add, row_add;
  logic [CntW:0]   cnt_add;
  logic            hit, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= ctc_pkg::HueLowRst;
      hue_high_q <= ctc_pkg::HueHighRst;
      sat_low_q  <= ctc_pkg::SatLowRst;
      sat_high_q <= ctc_pkg::SatHighRst;
      val_low_q  <= ctc_pkg::ValLowRst;
      val_high_q <= ctc_pkg::ValHighRst;
      min_pix_q  <= ctc_pkg::MinPixRst;
    end else if (cfg_we_i) begin
      unique case (ctc_pkg::cfg_reg_e'(cfg_idx_i))
        ctc_pkg::REG_HUE_LOW:   hue_low_q  <= cfg_data_i[ctc_pkg::PixW-1:0];
        ctc_pkg::REG_HUE_HIGH:  hue_high_q <= cfg_data_i[ctc_pkg::PixW-1:0];
        ctc_pkg::REG_SAT_LOW:   sat_low_q  <= cfg_data_i[ctc_pkg::PixW-1:0];
        ctc_pkg::REG_SAT_HIGH:  sat_high_q <= cfg_data_i[ctc_pkg::PixW-1:0];
        ctc_pkg::REG_VAL_LOW:   val_low_q  <= cfg_data_i[ctc_pkg::PixW-1:0];
        ctc_pkg::REG_VAL_HIGH:  val_high_q <= cfg_data_i[ctc_pkg::PixW-1:0];
        ctc_pkg::REG_MIN_PIXEL: min_pix_q  <= cfg_data_i[ctc_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  assign hit = (hue_i >= hue_low_q) && (hue_i <= hue_high_q) &&
               (sat_i >= sat_low_q) && (sat_i <= sat_high_q) &&
               (val_i >= val_low_q) && (val_i <= val_high_q);

  // saturating accumulation, this pixel included
  assign col_add = {1'b0, col_sum_q} + {{(SumW + 1 - PosW){1'b0}}, col_pos_q};
  assign row_add = {1'b0, row_sum_q} + {{(SumW + 1 - PosW){1'b0}}, row_pos_q};
  assign cnt_add = {1'b0, count_q} + {{CntW{1'b0}}, 1'b1};

  always_comb begin
    col_sum_d = col_sum_q;
    row_sum_d = row_sum_q;
    count_d   = count_q;
    if (hit) begin
      col_sum_d = col_add[SumW] ? {SumW{1'b1}} : col_add[SumW-1:0];
      row_sum_d = row_add[SumW] ? {SumW{1'b1}} : row_add[SumW-1:0];
      count_d   = cnt_add[CntW] ? {CntW{1'b1}} : cnt_add[CntW-1:0];
    end
  end

  assign accept       = in_valid_i && push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_data_o.mask      = hit;
    push_data_o.frame_end = frame_end_i;
    push_data_o.found     = frame_end_i &&
                            (count_d > {{(CntW - ctc_pkg::MinW){1'b0}}, min_pix_q});
    push_data_o.col_sum   = col_sum_d;
    push_data_o.row_sum   = row_sum_d;
    push_data_o.count     = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
      col_sum_q <= '0;
      row_sum_q <= '0;
      count_q   <= '0;
    end else if (accept) begin
      if (frame_end_i) begin
        col_pos_q <= '0;
        row_pos_q <= '0;
        col_sum_q <= '0;
        row_sum_q <= '0;
        count_q   <= '0;
      end else begin
        col_sum_q <= col_sum_d;
        row_sum_q <= row_sum_d;
        count_q   <= count_d;
        if (row_end_i) begin
          col_pos_q <= '0;
          if (row_pos_q < ROW_LIM) begin
            row_pos_q <= row_pos_q + PosW'(1);
          end
        end else if (col_pos_q < COL_LIM) begin
          col_pos_q <= col_pos_q + PosW'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/ctc_fifo.sv -----
// Short queue of classified pixels between front and back
`timescale 1ns / 1ps

module ctc_fifo #(
  parameter int Depth = ctc_pkg::DefQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ctc_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ctc_pkg::entry_t pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LAST = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FULL = CntW'(Depth);

  ctc_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/ctc_back.sv -----
// Back end: result register and bit-serial centroid divider
`timescale 1ns / 1ps

`include "color_threshold_centroid_defines.svh"

module ctc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  ctc_pkg::entry_t           pop_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      mask_o,
  output logic                      frame_done_o,
  output logic [ctc_pkg::PosW-1:0]  centre_col_o,
  output logic [ctc_pkg::PosW-1:0]  centre_row_o,
  output logic                      found_o
);

  localparam int PosW  = ctc_pkg::PosW;
  localparam int SumW  = ctc_pkg::SumW;
  localparam int CntW  = ctc_pkg::CntW;
  localparam int StepW = $clog2(SumW);
  localparam logic [StepW-1:0] LAST_STEP = StepW'(SumW - 1);

  typedef enum logic {ST_IDLE, ST_DIV} state_e;

  state_e           state_q;
  logic             out_valid_q, mask_q, frame_done_q, found_q;
  logic [PosW-1:0]  col_q, row_q;
  logic             div_mask_q;
  logic [SumW-1:0]  cdvd_q, rdvd_q, cquo_q, rquo_q;
  logic [CntW-1:0]  dvsr_q, crem_q, rrem_q;
  logic [StepW-1:0] step_q;
  logic             slot_free, pop, load_res;

  logic [CntW:0]    csh, rsh, csub, rsub;
  logic             cge, rge;
  logic [CntW-1:0]  crem_d, rrem_d;
  logic [SumW-1:0]  cquo_d, rquo_d;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == ST_IDLE) && slot_free;
  assign pop         = pop_valid_i && pop_ready_o;

  // result register loads on a plain pop or on the last divide step
  assign load_res = ((state_q == ST_IDLE) && pop && !pop_data_i.found) ||
                    ((state_q == ST_DIV) && (step_q == LAST_STEP));

  // restoring division step, both quotients share the divisor
  always_comb begin
    csh    = {crem_q, cdvd_q[SumW-1]};
    rsh    = {rrem_q, rdvd_q[SumW-1]};
    csub   = csh - {1'b0, dvsr_q};
    rsub   = rsh - {1'b0, dvsr_q};
    cge    = (csh >= {1'b0, dvsr_q});
    rge    = (rsh >= {1'b0, dvsr_q});
    crem_d = cge ? csub[CntW-1:0] : csh[CntW-1:0];
    rrem_d = rge ? rsub[CntW-1:0] : rsh[CntW-1:0];
    cquo_d = {cquo_q[SumW-2:0], cge};
    rquo_d = {rquo_q[SumW-2:0], rge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      mask_q       <= 1'b0;
      frame_done_q <= 1'b0;
      found_q      <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
      div_mask_q   <= 1'b0;
      cdvd_q       <= '0;
      rdvd_q       <= '0;
      cquo_q       <= '0;
      rquo_q       <= '0;
      dvsr_q       <= '0;
      crem_q       <= '0;
      rrem_q       <= '0;
      step_q       <= '0;
    end else begin
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            if (pop_data_i.found) begin
              state_q    <= ST_DIV;
              div_mask_q <= pop_data_i.mask;
              cdvd_q     <= pop_data_i.col_sum;
              rdvd_q     <= pop_data_i.row_sum;
              dvsr_q     <= pop_data_i.count;
              crem_q     <= '0;
              rrem_q     <= '0;
              cquo_q     <= '0;
              rquo_q     <= '0;
              step_q     <= '0;
            end else begin
              mask_q       <= pop_data_i.mask;
              frame_done_q <= pop_data_i.frame_end;
              found_q      <= 1'b0;
              col_q        <= '0;
              row_q        <= '0;
            end
          end
        end
        ST_DIV: begin
          crem_q <= crem_d;
          rrem_q <= rrem_d;
          cquo_q <= cquo_d;
          rquo_q <= rquo_d;
          cdvd_q <= {cdvd_q[SumW-2:0], 1'b0};
          rdvd_q <= {rdvd_q[SumW-2:0], 1'b0};
          step_q <= step_q + StepW'(1);
          if (step_q == LAST_STEP) begin
            // slot already drained: nothing loads it while dividing
            state_q      <= ST_IDLE;
            mask_q       <= div_mask_q;
            frame_done_q <= 1'b1;
            found_q      <= 1'b1;
            col_q        <= (|cquo_d[SumW-1:PosW]) ? {PosW{1'b1}} : cquo_d[PosW-1:0];
            row_q        <= (|rquo_d[SumW-1:PosW]) ? {PosW{1'b1}} : rquo_d[PosW-1:0];
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mask_o       = mask_q;
  assign frame_done_o = frame_done_q;
  assign centre_col_o = col_q;
  assign centre_row_o = row_q;
  assign found_o      = found_q;

  `CTC_ASSERT(a_div_slot_empty, (state_q == ST_DIV) |-> !out_valid_q, "result pending during divide")

  `CTC_ASSERT(a_div_nonzero, (state_q == ST_DIV) |-> (dvsr_q != '0), "divide by zero count")

  `CTC_ASSERT_ALWAYS(a_found_on_frame, (out_valid_o && found_o) |-> frame_done_o, "found off frame end")

endmodule

// ----- rtl/color_threshold_centroid.sv -----
// Top level: HSV threshold mask with per-frame blob centroid
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i                 | in
//  pixel   | in_valid_i/in_ready_o, hue/sat/val, row/frame   | in
//  result  | out_valid_o/out_ready_i, mask, frame_done, ...  | out
//
// Ordinary pixels: one beat per cycle while nothing stalls, through a queue entry and the result reg.
// Frame end with a centroid: the back end runs a bit-serial divide and pops nothing until it ends;
// the queue (4 entries by default) keeps taking pixels meanwhile.
// Reset restores the threshold registers and clears position, sums and count.
// Pixel input stalls only when the queue is full; result stalls back up into it.
`timescale 1ns / 1ps

module color_threshold_centroid #(
  parameter int MaxCols    = ctc_pkg::DefMaxCols,
  parameter int MaxRows    = ctc_pkg::DefMaxRows,
  parameter int QueueDepth = ctc_pkg::DefQueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ctc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ctc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ctc_pkg::PixW-1:0]     hue_i,
  input  logic [ctc_pkg::PixW-1:0]     sat_i,
  input  logic [ctc_pkg::PixW-1:0]     val_i,
  input  logic                         row_end_i,
  input  logic                         frame_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         mask_o,
  output logic                         frame_done_o,
  output logic [ctc_pkg::PosW-1:0]     centre_col_o,
  output logic [ctc_pkg::PosW-1:0]     centre_row_o,
  output logic                         found_o
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  ctc_pkg::entry_t push_data, pop_data;

  ctc_front #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_i        (hue_i),
    .sat_i        (sat_i),
    .val_i        (val_i),
    .row_end_i    (row_end_i),
    .frame_end_i  (frame_end_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ctc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ctc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mask_o       (mask_o),
    .frame_done_o (frame_done_o),
    .centre_col_o (centre_col_o),
    .centre_row_o (centre_row_o),
    .found_o      (found_o)
  );

endmodule
